@@ src/rnav_pkg.sv @@
// Shared types, constants and the range conversion table for the rover navigation block.
// Depends on nothing; every other file in src imports it.
package rnav_pkg;

	// Number of range sensors carried by one input item.
	localparam int NumLanes = 6;

	// Distance scale and limits.
	localparam int RangeNumer = 6762;
	localparam int RangeOffset = 4;
	localparam int DistCap = 100;

	// Motor commands.
	localparam logic [6:0] SPD_STOP = 7'd64;
	localparam logic [6:0] SPD_FAST = 7'd88;
	localparam logic [6:0] SPD_FAST_TRIM = 7'd86;
	localparam logic [6:0] SPD_VEER_HI = 7'd91;
	localparam logic [6:0] SPD_VEER_LO = 7'd74;
	localparam logic [6:0] SPD_MED = 7'd79;
	localparam logic [6:0] SPD_PIVOT_BACK = 7'd44;

	// Configuration register indexes (byte address is four times the index).
	typedef enum logic [2:0] {
		REG_RUN_ENABLE,
		REG_NEAR_DIST,
		REG_VEER_DIST,
		REG_SONAR_VEER_DIST,
		REG_CORNER_ENTER_DIST,
		REG_CORNER_EXIT_DIST
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_STRAIGHT,
		MODE_NINETY,
		MODE_TURN
	} nav_mode_t;

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_LEFT,
		DIR_RIGHT
	} turn_dir_t;

	// Configuration as seen by the decision logic.
	typedef struct packed {
		logic       run_enable;
		logic [6:0] near_distance;
		logic [6:0] veer_distance;
		logic [6:0] sonar_veer_distance;
		logic [6:0] corner_enter_distance;
		logic [6:0] corner_exit_distance;
	} nav_cfg_t;

	// Result of one navigation decision.
	typedef struct packed {
		logic [6:0] left_speed;
		logic [6:0] right_speed;
		nav_mode_t  mode;
		turn_dir_t  direction;
	} nav_res_t;

	typedef logic [6:0] dist_lut_t [256];

	// Distance for one raw reading, or zero when the stored distance is kept.
	// Only used to build the constant table below; the quotient is formed by
	// shift and subtract over the bits of the fixed numerator.
	function automatic logic [6:0] raw_to_dist(input int raw);
		int den;
		int rem;
		int quo;
		int dist_cm;
		if (raw < 3) begin
			return 7'd0;
		end
		den = 4 * raw - 9;
		rem = 0;
		quo = 0;
		for (int i = 12; i >= 0; i--) begin
			rem = (rem << 1) | ((RangeNumer >> i) & 1);
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | (1 << i);
			end
		end
		dist_cm = quo - RangeOffset;
		if (dist_cm > DistCap) begin
			dist_cm = DistCap;
		end
		return 7'(dist_cm);
	endfunction

	function automatic dist_lut_t build_dist_lut();
		dist_lut_t lut;
		for (int r = 0; r < 256; r++) begin
			lut[r] = raw_to_dist(r);
		end
		return lut;
	endfunction

	// Raw byte to distance; an entry of zero means the reading is ignored.
	localparam dist_lut_t DIST_LUT = build_dist_lut();

endpackage

@@ src/rover_obstacle_nav_controller_top.sv @@
// Top level of the rover obstacle navigation controller: stream ports, APB registers.
// Depends on rnav_pkg, rnav_lane and rnav_nav.

// Each input item carries six raw range bytes; six lanes convert them in
// parallel through a constant table and keep the last valid distance, then the
// mode machine picks the motor commands. The lane registers load when an item is
// accepted; the mode decision and output load follow as it leaves the conversion stage.
// One item is in the conversion stage at a time, and the next item is taken only
// once that stage has emptied; a result waiting in the output register keeps the
// converted item in its stage, and so holds off the next item, until it is taken.
// Registers sit at byte addresses 0, 4, ... 20 and should only be written
// while no item is in flight.
module rover_obstacle_nav_controller_top
	import rnav_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// left_front_raw[7:0], right_front_raw[15:8], left_back_raw[23:16],
	// right_back_raw[31:24], sonar_left_raw[39:32], sonar_right_raw[47:40]
	input  logic [47:0] s_tdata,
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// left_speed[6:0], right_speed[13:7], mode_out[15:14], direction_out[17:16],
	// left_front_dist[24:18], right_front_dist[31:25], left_back_dist[38:32],
	// right_back_dist[45:39], sonar_left_dist[52:46], sonar_right_dist[59:53],
	// zero[63:60]
	output logic [63:0] m_tdata,
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	nav_cfg_t   cfg_q;
	logic       conv_v_s1;
	logic       out_v_q;
	logic [63:0] out_data_q;
	logic       s_acc;
	logic       step;
	logic [6:0] lane_dist [NumLanes];
	nav_res_t   res;
	reg_idx_t   reg_idx;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_enable <= 1'b0;
			cfg_q.near_distance <= 7'd13;
			cfg_q.veer_distance <= 7'd21;
			cfg_q.sonar_veer_distance <= 7'd45;
			cfg_q.corner_enter_distance <= 7'd50;
			cfg_q.corner_exit_distance <= 7'd65;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_RUN_ENABLE:        cfg_q.run_enable <= pwdata[0];
				REG_NEAR_DIST:         cfg_q.near_distance <= pwdata[6:0];
				REG_VEER_DIST:         cfg_q.veer_distance <= pwdata[6:0];
				REG_SONAR_VEER_DIST:   cfg_q.sonar_veer_distance <= pwdata[6:0];
				REG_CORNER_ENTER_DIST: cfg_q.corner_enter_distance <= pwdata[6:0];
				REG_CORNER_EXIT_DIST:  cfg_q.corner_exit_distance <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_idx)
			REG_RUN_ENABLE:        prdata = {31'd0, cfg_q.run_enable};
			REG_NEAR_DIST:         prdata = {25'd0, cfg_q.near_distance};
			REG_VEER_DIST:         prdata = {25'd0, cfg_q.veer_distance};
			REG_SONAR_VEER_DIST:   prdata = {25'd0, cfg_q.sonar_veer_distance};
			REG_CORNER_ENTER_DIST: prdata = {25'd0, cfg_q.corner_enter_distance};
			REG_CORNER_EXIT_DIST:  prdata = {25'd0, cfg_q.corner_exit_distance};
			default:               prdata = 32'd0;
		endcase
	end

	// Handshake: an item enters when the conversion stage is empty, and moves
	// on to the output register once that is free or its result is being taken.
	assign s_tready = !conv_v_s1;
	assign s_acc = s_tvalid && s_tready;
	assign step = conv_v_s1 && (!out_v_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_acc) begin
				conv_v_s1 <= 1'b1;
			end else if (step) begin
				conv_v_s1 <= 1'b0;
			end
			if (step) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Conversion lanes, one per sensor byte.
	for (genvar g = 0; g < NumLanes; g++) begin : g_lane
		rnav_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (s_acc),
			.raw      (s_tdata[8*g +: 8]),
			.dist_out (lane_dist[g])
		);
	end

	// Mode decision on the front and sonar distances.
	rnav_nav u_nav (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.lf     (lane_dist[0]),
		.rf     (lane_dist[1]),
		.sl     (lane_dist[4]),
		.sr     (lane_dist[5]),
		.res    (res)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {4'd0, lane_dist[5], lane_dist[4], lane_dist[3], lane_dist[2],
				lane_dist[1], lane_dist[0],
				res.direction, res.mode, res.right_speed, res.left_speed};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_data_q;

`ifndef SYNTHESIS
	// An accepted item is waiting in the conversion stage on the next cycle.
	a_accept_to_stage: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> conv_v_s1)
		else $error("accepted item did not reach the conversion stage");

	// A ninety-degree turn always has a direction.
	a_ninety_has_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (res.mode == MODE_NINETY)) |-> (res.direction != DIR_NONE))
		else $error("ninety turn without a direction");

	// Stopped navigation holds both motors at the stop command.
	a_stop_speeds: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !cfg_q.run_enable) |=>
		((m_tdata[6:0] == SPD_STOP) && (m_tdata[13:7] == SPD_STOP)))
		else $error("motors not stopped while navigation is off");

	// Stored front and sonar distances never exceed the cap.
	a_dist_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_dist[0] <= 7'(DistCap)) && (lane_dist[1] <= 7'(DistCap))
		&& (lane_dist[4] <= 7'(DistCap)) && (lane_dist[5] <= 7'(DistCap)))
		else $error("distance above cap");
`endif

endmodule

@@ src/rnav_lane.sv @@
// One sensor lane: converts a raw range byte and holds the last valid distance.
// Depends on rnav_pkg for the conversion table.
module rnav_lane
	import rnav_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [7:0] raw,
	output logic [6:0] dist_out
);

	logic [6:0] dist_q;
	logic [6:0] conv;

	// Table lookup; zero marks a reading that keeps the old distance.
	assign conv = DIST_LUT[raw];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (load && (conv != 7'd0)) begin
			dist_q <= conv;
		end
	end

	assign dist_out = dist_q;

endmodule

@@ src/rnav_nav.sv @@
// Merge stage: mode machine that turns the lane distances into motor commands.
// Depends on rnav_pkg for the mode, direction and configuration types and the speed commands.
module rnav_nav
	import rnav_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  nav_cfg_t   cfg,
	input  logic [6:0] lf,
	input  logic [6:0] rf,
	input  logic [6:0] sl,
	input  logic [6:0] sr,
	output nav_res_t   res
);

	nav_mode_t mode_q;
	turn_dir_t dir_q;
	nav_mode_t mode_n;
	turn_dir_t dir_n;
	logic [6:0] ls;
	logic [6:0] rs;

	// Straight may hand over to ninety or turn, which are then evaluated
	// again within the same item.
	always_comb begin
		mode_n = mode_q;
		dir_n = dir_q;
		ls = SPD_STOP;
		rs = SPD_STOP;
		if (cfg.run_enable) begin
			if (mode_q == MODE_STRAIGHT) begin
				if ((sl < cfg.corner_enter_distance) && (sr < cfg.corner_enter_distance)) begin
					mode_n = MODE_NINETY;
					dir_n = (rf > lf) ? DIR_RIGHT : DIR_LEFT;
				end else if (lf < cfg.near_distance) begin
					mode_n = MODE_TURN;
					dir_n = DIR_RIGHT;
				end else if (rf < cfg.near_distance) begin
					mode_n = MODE_TURN;
					dir_n = DIR_LEFT;
				end else if (lf < cfg.veer_distance) begin
					ls = SPD_VEER_HI;
					rs = SPD_VEER_LO;
				end else if (rf < cfg.veer_distance) begin
					ls = SPD_VEER_LO;
					rs = SPD_VEER_HI;
				end else if (sl < cfg.sonar_veer_distance) begin
					ls = SPD_VEER_HI;
					rs = SPD_VEER_LO;
				end else if (sr < cfg.sonar_veer_distance) begin
					ls = SPD_VEER_LO;
					rs = SPD_VEER_HI;
				end else if (lf < rf) begin
					ls = SPD_FAST;
					rs = SPD_FAST_TRIM;
				end else if (rf < lf) begin
					ls = SPD_FAST_TRIM;
					rs = SPD_FAST;
				end else begin
					ls = SPD_FAST;
					rs = SPD_FAST;
				end
			end

			// Ninety-degree and pivot turns, on the mode left by straight.
			if (mode_n == MODE_NINETY) begin
				if (!((sl < cfg.corner_exit_distance) && (sr < cfg.corner_exit_distance))) begin
					mode_n = MODE_STRAIGHT;
					dir_n = DIR_NONE;
				end else if (dir_n == DIR_LEFT) begin
					ls = SPD_PIVOT_BACK;
					rs = SPD_MED;
				end else if (dir_n == DIR_RIGHT) begin
					ls = SPD_MED;
					rs = SPD_PIVOT_BACK;
				end
			end else if (mode_n == MODE_TURN) begin
				if (dir_n == DIR_RIGHT) begin
					ls = SPD_MED;
					rs = SPD_PIVOT_BACK;
					if (lf >= cfg.near_distance) begin
						mode_n = MODE_STRAIGHT;
					end
				end else if (dir_n == DIR_LEFT) begin
					ls = SPD_PIVOT_BACK;
					rs = SPD_MED;
					if (rf >= cfg.near_distance) begin
						mode_n = MODE_STRAIGHT;
					end
				end
			end
		end
	end

	// Mode and direction advance once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STRAIGHT;
			dir_q <= DIR_NONE;
		end else if (step) begin
			mode_q <= mode_n;
			dir_q <= dir_n;
		end
	end

	assign res.left_speed = ls;
	assign res.right_speed = rs;
	assign res.mode = mode_n;
	assign res.direction = dir_n;

endmodule
